### src/huffman_bit_packer_unit_defines.svh
// ----------------------------------------------------------------------------
// huffman bit packer assertion macros
// shared assertion helpers for the packer rtl
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_BIT_PACKER_UNIT_DEFINES_SVH

// checked only outside reset
`define HBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// widths, codes and defaults shared by the bit packer files
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int SYM_W      = 8;
  localparam int CODE_W     = 32;
  localparam int CODE_IDX_W = 5;
  localparam int LEN_IN_W   = 6;
  localparam int LEN_CMP_W  = 7;
  localparam int BYTE_W     = 8;
  localparam int BITPOS_W   = 3;

  localparam int MAX_CODE_LEN_DEF  = 32;
  localparam int ALPHABET_SIZE_DEF = 256;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  localparam logic [BITPOS_W-1:0] BYTE_TOP = 3'd7;

endpackage

### src/hbp_in_if.sv
// ----------------------------------------------------------------------------
// hbp_in_if
// request channel: table loads and symbols to encode
// ----------------------------------------------------------------------------
interface hbp_in_if import hbp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [SYM_W-1:0]    symbol;
  logic [CODE_W-1:0]   code_bits;
  logic [LEN_IN_W-1:0] code_length;
  logic                end_of_message;

  modport source (
    output valid, operation, symbol, code_bits, code_length, end_of_message,
    input  ready
  );
  modport sink (
    input  valid, operation, symbol, code_bits, code_length, end_of_message,
    output ready
  );
endinterface

### src/hbp_out_if.sv
// ----------------------------------------------------------------------------
// hbp_out_if
// result channel: packed bytes with final and error flags
// ----------------------------------------------------------------------------
interface hbp_out_if import hbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              final_byte;
  logic              unknown_symbol;

  modport source (
    output valid, packed_byte, final_byte, unknown_symbol,
    input  ready
  );
  modport sink (
    input  valid, packed_byte, final_byte, unknown_symbol,
    output ready
  );
endinterface

### src/hbp_ram.sv
// ----------------------------------------------------------------------------
// hbp_ram
// generic ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/huffman_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_bit_packer_unit
// huffman encoder with an internal code table, packing code bits into bytes
// ----------------------------------------------------------------------------
// request channel: operation load writes one table entry (code, length) and
// marks it valid; operation encode looks up the symbol and appends its code
// bits msb first into the byte being filled. result channel: one request
// gives zero to five results, each a packed byte, a final flag on the last
// result of a message, or an unknown_symbol flag for a symbol with no entry.
// an encode passes through acceptance, the code table read, the bit-serial
// packer, which packs the code bits one by one, and the end-of-message
// flush; an unknown symbol or empty code skips the packer. the last bit of
// a byte is packed straight into the result register.
// reset clears all valid marks, the partial byte and the result valid flag;
// code and length entries hold anything until loaded.
// a stalled result register holds the bit packer, which resumes as soon as
// the receiver takes the waiting byte; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module huffman_bit_packer_unit import hbp_pkg::*; #(
  parameter int MAX_CODE_LEN  = MAX_CODE_LEN_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  hbp_in_if.sink     request,
  hbp_out_if.source  result
);

  `include "huffman_bit_packer_unit_defines.svh"

  localparam int ADDR_W  = $clog2(ALPHABET_SIZE);
  localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
  localparam int ENTRY_W = LEN_W + CODE_W;
  localparam int IDX_W   = LEN_W + CODE_IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_UNK   = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;

  logic [2:0]               state;
  logic [ALPHABET_SIZE-1:0] entry_valid;
  logic                     eom;
  logic [CODE_W-1:0]        code_reg;
  logic [LEN_W-1:0]         remaining;
  logic [BYTE_W-1:0]        partial_byte;
  logic [BITPOS_W-1:0]      bit_pos;

  logic                     out_valid;
  logic [BYTE_W-1:0]        out_byte;
  logic                     out_final;
  logic                     out_unknown;

  logic                     accept;
  logic                     sym_in_range;
  logic [ADDR_W-1:0]        sym_addr;
  logic [LEN_W-1:0]         len_clamped;
  logic                     ram_we;
  logic [ENTRY_W-1:0]       ram_rdata;
  logic [LEN_W-1:0]         rd_len;
  logic [LEN_W-1:0]         bit_idx;
  logic [IDX_W-1:0]         idx_ext;
  logic                     cur_bit;
  logic                     last_bit;
  logic [BYTE_W-1:0]        filled;
  logic                     slot_free;
  logic                     emit;

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;

  assign sym_in_range = {1'b0, request.symbol} < (SYM_W + 1)'(ALPHABET_SIZE);
  assign sym_addr     = request.symbol[ADDR_W-1:0];

  // overlong lengths saturate at the longest code
  assign len_clamped = (LEN_CMP_W'(request.code_length) > LEN_CMP_W'(MAX_CODE_LEN)) ?
                       LEN_W'(MAX_CODE_LEN) : LEN_W'(request.code_length);

  assign ram_we = accept && (request.operation == OP_LOAD) && sym_in_range;

  hbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sym_addr),
    .wdata ({len_clamped, request.code_bits}),
    .raddr (sym_addr),
    .rdata (ram_rdata)
  );

  assign rd_len = ram_rdata[ENTRY_W-1:CODE_W];

  // bits above the stored code width read as zero
  always_comb begin
    bit_idx   = remaining - LEN_W'(1);
    idx_ext   = IDX_W'(bit_idx);
    cur_bit   = (idx_ext < IDX_W'(CODE_W)) ? code_reg[idx_ext[CODE_IDX_W-1:0]] : 1'b0;
    last_bit  = (remaining == LEN_W'(1));
    filled    = partial_byte | (BYTE_W'(cur_bit) << bit_pos);
    slot_free = !out_valid || result.ready;
    // a new result is loaded into the output register this cycle
    case (state)
      S_SHIFT: emit = slot_free && (bit_pos == '0);
      S_UNK:   emit = slot_free;
      S_END:   emit = slot_free && eom && (bit_pos != BYTE_TOP);
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_valid  <= '0;
      partial_byte <= '0;
      bit_pos      <= BYTE_TOP;
      out_valid    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.operation == OP_LOAD) begin
              if (sym_in_range) begin
                entry_valid[sym_addr] <= 1'b1;
              end
            end else begin
              eom <= request.end_of_message;
              if (sym_in_range && entry_valid[sym_addr]) begin
                state <= S_READ;
              end else begin
                state <= S_UNK;
              end
            end
          end
        end
        S_READ: begin
          code_reg  <= ram_rdata[CODE_W-1:0];
          remaining <= rd_len;
          state     <= (rd_len == '0) ? S_END : S_SHIFT;
        end
        S_SHIFT: begin
          if (slot_free) begin
            remaining <= remaining - LEN_W'(1);
            if (bit_pos == '0) begin
              out_byte     <= filled;
              out_final    <= eom && last_bit;
              out_unknown  <= 1'b0;
              partial_byte <= '0;
              bit_pos      <= BYTE_TOP;
            end else begin
              partial_byte <= filled;
              bit_pos      <= bit_pos - BITPOS_W'(1);
            end
            if (last_bit) begin
              state <= S_END;
            end
          end
        end
        S_UNK: begin
          if (slot_free) begin
            out_byte    <= '0;
            out_final   <= eom && (bit_pos == BYTE_TOP);
            out_unknown <= 1'b1;
            state       <= S_END;
          end
        end
        S_END: begin
          // flush a partly filled byte at message end
          if (eom && (bit_pos != BYTE_TOP)) begin
            if (slot_free) begin
              out_byte     <= partial_byte;
              out_final    <= 1'b1;
              out_unknown  <= 1'b0;
              partial_byte <= '0;
              bit_pos      <= BYTE_TOP;
              state        <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.packed_byte    = out_byte;
  assign result.final_byte     = out_final;
  assign result.unknown_symbol = out_unknown;

  `HBP_ASSERT(a_shift_has_bits, (state == S_SHIFT) |-> (remaining != '0),
              "shift with no bits left")
  `HBP_ASSERT_ALWAYS(a_reset_byte_start,
                     $past(rst) |-> (bit_pos == BYTE_TOP && partial_byte == '0),
                     "byte not restarted by reset")
  `HBP_ASSERT(a_unfilled_bits_zero,
              (partial_byte & ((8'd2 << bit_pos) - 8'd1)) == 8'd0,
              "unfilled bits of partial byte set")
  `HBP_ASSERT(a_unknown_byte_zero, (out_valid && out_unknown) |-> (out_byte == '0),
              "unknown symbol result carries data")

endmodule
